>>> rtl/bpd_pkg.sv
// Package for the BPS patch command decoder.
// Holds the phase, token and result types, field widths and the magic bytes.
// No dependencies.
`default_nettype none
package bpd_pkg;

	localparam int TOK_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 2;
	localparam int MAX_GROUPS = 10;
	localparam int LIVE_GROUPS = 5;

	typedef enum logic [3:0] {
		P_MAGIC, P_SRC, P_DST, P_META, P_SKIP, P_CMD, P_LIT, P_REL, P_FINISH, P_HALT
	} phase_t;

	typedef enum logic [2:0] {
		K_SREAD = 3'd0, K_LIT = 3'd1, K_SCOPY = 3'd2, K_TCOPY = 3'd3,
		K_HDR = 3'd4, K_DONE = 3'd5, K_ERR = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE = 3'd0, E_MAGIC = 3'd1, E_SRC = 3'd2, E_TRUNC = 3'd3, E_DST = 3'd4
	} err_t;

	// front to back: kind K_DONE means final check, K_ERR carries a code
	typedef struct packed {
		kind_t       op;
		err_t        code;
		logic        bump;    // literal advanced the offset before the error
		logic        set_dts; // header size arrives with the error
		logic [30:0] len;
		logic [31:0] val;
		logic [7:0]  lit;
	} token_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] write_address;
		logic [31:0] read_address;
		logic [30:0] copy_length;
		logic [7:0]  literal_value;
		logic [31:0] target_size;
		err_t        error_code;
	} result_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		logic [7:0] r;
		unique case (pos)
			2'd0: r = 8'h42;
			2'd1: r = 8'h50;
			2'd2: r = 8'h53;
			default: r = 8'h31;
		endcase
		return r;
	endfunction

	// low 32 bits of 2^(7*groups)
	function automatic logic [31:0] group_weight(input logic [3:0] groups);
		logic [31:0] r;
		r = 32'd0;
		if (groups < 4'(LIVE_GROUPS))
			r = 32'd1 << (6'(groups) * 6'd7);
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/bpd_fifo.sv
// Small synchronous FIFO used for the token queue and the result queue.
// Depends on nothing; DEPTH must be a power of two.
`default_nettype none
module bpd_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + AW'(1);
			if (do_pop)
				rd_q <= rd_q + AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("fifo overfilled");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("fifo count missed a push");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> count_q == $past(count_q) - CW'(1))
		else $error("fifo count missed a pop");

endmodule
`default_nettype wire

>>> rtl/bpd_front.sv
// Front end: checks the magic, decodes the varints, skips metadata and
// turns each patch byte into at most one token. Depends on bpd_pkg.
`default_nettype none
module bpd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	input  wire logic [31:0]   cfg_data,
	input  wire logic          push,
	input  wire logic [7:0]    patch_byte,
	input  wire logic          body_end,
	input  wire logic          tok_full,
	output logic               tok_push,
	output bpd_pkg::token_t    tok
);
	import bpd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  mpos_q, mpos_d;
	logic [31:0] vval_q, vval_d;
	logic [3:0]  vsh_q, vsh_d;
	logic [31:0] pend_q, pend_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] src_size_q;

	logic [31:0] vsum, vnow, rem_m1;
	logic [3:0]  sh_inc;
	logic        vdone, emitted, accept;
	err_t        err;
	logic [30:0] len_now, len_pend;

	assign accept   = push && !tok_full;
	assign len_now  = {1'b0, vsum[31:2]} + 31'd1;
	assign len_pend = {1'b0, pend_q[31:2]} + 31'd1;
	assign rem_m1   = rem_q - 32'd1;

	// varint group add
	always_comb begin
		vdone  = patch_byte[7];
		sh_inc = (vsh_q < 4'(MAX_GROUPS)) ? vsh_q + 4'd1 : vsh_q;
		vsum   = vval_q;
		if (vsh_q < 4'(LIVE_GROUPS))
			vsum = vval_q + ({25'd0, patch_byte[6:0]} << (6'(vsh_q) * 6'd7));
		vnow   = vsum + group_weight(sh_inc);
	end

	// phase machine
	always_comb begin
		phase_d  = phase_q;
		mpos_d   = mpos_q;
		vval_d   = vval_q;
		vsh_d    = vsh_q;
		pend_d   = pend_q;
		rem_d    = rem_q;
		err      = E_NONE;
		emitted  = 1'b0;
		tok_push = 1'b0;
		tok      = '0;
		if (accept && phase_q != P_HALT) begin
			if (phase_q == P_FINISH) begin
				tok.op   = K_DONE;
				tok_push = 1'b1;
				phase_d  = P_HALT;
			end else begin
				// varint phases share the accumulator
				if (phase_q == P_SRC || phase_q == P_DST || phase_q == P_META ||
				    phase_q == P_CMD || phase_q == P_REL) begin
					if (vdone) begin
						vval_d = '0;
						vsh_d  = '0;
					end else begin
						vval_d = vnow;
						vsh_d  = sh_inc;
					end
				end
				unique case (phase_q)
					P_MAGIC: begin
						if (patch_byte != magic_byte(mpos_q))
							err = E_MAGIC;
						else if (mpos_q == 2'd3) begin
							mpos_d  = '0;
							phase_d = P_SRC;
						end else
							mpos_d = mpos_q + 2'd1;
					end
					P_SRC: begin
						if (vdone) begin
							if (vsum != src_size_q)
								err = E_SRC;
							else
								phase_d = P_DST;
						end
					end
					P_DST: begin
						if (vdone) begin
							tok.op  = K_HDR;
							tok.val = vsum;
							emitted = 1'b1;
							phase_d = P_META;
						end
					end
					P_META: begin
						if (vdone) begin
							rem_d   = vsum;
							phase_d = (vsum != '0) ? P_SKIP : P_CMD;
						end
					end
					P_SKIP: begin
						rem_d = rem_m1;
						if (rem_m1 == '0)
							phase_d = P_CMD;
					end
					P_CMD: begin
						if (vdone) begin
							pend_d = vsum;
							unique case (vsum[1:0])
								2'd0: begin
									tok.op  = K_SREAD;
									tok.len = len_now;
									emitted = 1'b1;
								end
								2'd1: begin
									rem_d   = {1'b0, len_now};
									phase_d = P_LIT;
								end
								default: phase_d = P_REL;
							endcase
						end
					end
					P_LIT: begin
						tok.op  = K_LIT;
						tok.lit = patch_byte;
						emitted = 1'b1;
						rem_d   = rem_m1;
						if (rem_m1 == '0)
							phase_d = P_CMD;
					end
					P_REL: begin
						if (vdone) begin
							tok.op  = (pend_q[1:0] == 2'd2) ? K_SCOPY : K_TCOPY;
							tok.len = len_pend;
							tok.val = vsum;
							emitted = 1'b1;
							phase_d = P_CMD;
						end
					end
					default: ;
				endcase
				// errors, truncation and clean end
				if (err != E_NONE) begin
					tok      = '0;
					tok.op   = K_ERR;
					tok.code = err;
					tok_push = 1'b1;
					phase_d  = P_HALT;
				end else if (body_end) begin
					if (phase_d != P_CMD || vsh_d != '0) begin
						tok.bump    = emitted && (tok.op == K_LIT);
						tok.set_dts = emitted && (tok.op == K_HDR);
						tok.op      = K_ERR;
						tok.code    = E_TRUNC;
						tok_push    = 1'b1;
						phase_d     = P_HALT;
					end else if (emitted) begin
						tok_push = 1'b1;
						phase_d  = P_FINISH;
					end else begin
						tok.op   = K_DONE;
						tok_push = 1'b1;
						phase_d  = P_HALT;
					end
				end else
					tok_push = emitted;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= P_MAGIC;
			mpos_q     <= '0;
			vval_q     <= '0;
			vsh_q      <= '0;
			pend_q     <= '0;
			rem_q      <= '0;
			src_size_q <= '0;
		end else begin
			phase_q <= phase_d;
			mpos_q  <= mpos_d;
			vval_q  <= vval_d;
			vsh_q   <= vsh_d;
			pend_q  <= pend_d;
			rem_q   <= rem_d;
			if (cfg_valid)
				src_size_q <= cfg_data;
		end
	end

endmodule
`default_nettype wire

>>> rtl/bpd_back.sv
// Back end: keeps the output offset, both relative pointers and the declared
// size, and turns tokens into result items. Depends on bpd_pkg.
`default_nettype none
module bpd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          tok_empty,
	input  wire bpd_pkg::token_t tok,
	output logic               tok_pop,
	input  wire logic          res_full,
	output logic               res_push,
	output bpd_pkg::result_t   res
);
	import bpd_pkg::*;

	logic [31:0] off_q, off_d, srel_q, srel_d, trel_q, trel_d, dts_q, dts_d;
	logic [31:0] rel_base, rel_new, off_err, dts_err;

	assign tok_pop  = !tok_empty && !res_full;
	assign res_push = tok_pop;

	// relative pointer step
	always_comb begin
		rel_base = (tok.op == K_SCOPY) ? srel_q : trel_q;
		rel_new  = tok.val[0] ? rel_base - {1'b0, tok.val[31:1]}
		                      : rel_base + {1'b0, tok.val[31:1]};
		off_err  = tok.bump ? off_q + 32'd1 : off_q;
		dts_err  = tok.set_dts ? tok.val : dts_q;
	end

	// token to result
	always_comb begin
		off_d  = off_q;
		srel_d = srel_q;
		trel_d = trel_q;
		dts_d  = dts_q;
		res    = '0;
		res.kind = tok.op;
		unique case (tok.op)
			K_SREAD: begin
				res.write_address = off_q;
				res.read_address  = off_q;
				res.copy_length   = tok.len;
				off_d             = off_q + {1'b0, tok.len};
			end
			K_LIT: begin
				res.write_address = off_q;
				res.copy_length   = 31'd1;
				res.literal_value = tok.lit;
				off_d             = off_q + 32'd1;
			end
			K_SCOPY, K_TCOPY: begin
				res.write_address = off_q;
				res.read_address  = rel_new;
				res.copy_length   = tok.len;
				off_d             = off_q + {1'b0, tok.len};
				if (tok.op == K_SCOPY)
					srel_d = rel_new + {1'b0, tok.len};
				else
					trel_d = rel_new + {1'b0, tok.len};
			end
			K_HDR: begin
				res.target_size = tok.val;
				dts_d           = tok.val;
			end
			K_DONE: begin
				res.write_address = off_q;
				res.target_size   = dts_q;
				if (off_q != dts_q) begin
					res.kind       = K_ERR;
					res.error_code = E_DST;
				end
			end
			K_ERR: begin
				res.write_address = off_err;
				res.target_size   = dts_err;
				res.error_code    = tok.code;
				off_d             = off_err;
				dts_d             = dts_err;
			end
			default: res.kind = K_ERR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			srel_q <= '0;
			trel_q <= '0;
			dts_q  <= '0;
		end else if (tok_pop) begin
			off_q  <= off_d;
			srel_q <= srel_d;
			trel_q <= trel_d;
			dts_q  <= dts_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/bps_patch_command_decoder.sv
// Top level of the BPS patch command decoder: front end, token queue,
// back end and result queue. Depends on bpd_pkg and all bpd_* modules.
//
//  channel   handshake                   payload
//  input     push / full                 patch_byte, body_end
//  result    empty / pop                 kind .. error_code
//  config    cfg_valid / cfg_ready       cfg_data (expected source size)
//
// One patch byte is taken every cycle while the token queue has room; a
// result reaches the result ports through the token queue, then the result
// queue, and can be popped once it is there.
// Reset clears the phase, all offsets and both queues.
// A stalled pop fills the result queue, then the token queue, then raises full.
`default_nettype none
module bps_patch_command_decoder #(
	parameter int TOK_DEPTH = bpd_pkg::TOK_DEPTH_DEF,
	parameter int OUT_DEPTH = bpd_pkg::OUT_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  patch_byte,
	input  wire logic        body_end,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       kind,
	output logic [31:0]      write_address,
	output logic [31:0]      read_address,
	output logic [30:0]      copy_length,
	output logic [7:0]       literal_value,
	output logic [31:0]      target_size,
	output logic [2:0]       error_code
);
	import bpd_pkg::*;

	token_t  tok_in, tok_out;
	result_t res_in, res_out;
	logic    tok_push, tok_full, tok_empty, tok_pop, res_push, res_full;

	assign cfg_ready = 1'b1;
	assign full      = tok_full;

	bpd_front u_front (
		.clk, .arst_n, .cfg_valid, .cfg_data, .push, .patch_byte, .body_end,
		.tok_full, .tok_push, .tok(tok_in)
	);

	bpd_fifo #(.DEPTH(TOK_DEPTH), .WIDTH($bits(token_t))) u_tokq (
		.clk, .arst_n, .push(tok_push), .wdata(tok_in), .full(tok_full),
		.pop(tok_pop), .rdata(tok_out), .empty(tok_empty)
	);

	bpd_back u_back (
		.clk, .arst_n, .tok_empty, .tok(tok_out), .tok_pop,
		.res_full, .res_push, .res(res_in)
	);

	bpd_fifo #(.DEPTH(OUT_DEPTH), .WIDTH($bits(result_t))) u_resq (
		.clk, .arst_n, .push(res_push), .wdata(res_in), .full(res_full),
		.pop, .rdata(res_out), .empty
	);

	assign kind          = res_out.kind;
	assign write_address = res_out.write_address;
	assign read_address  = res_out.read_address;
	assign copy_length   = res_out.copy_length;
	assign literal_value = res_out.literal_value;
	assign target_size   = res_out.target_size;
	assign error_code    = res_out.error_code;

endmodule
`default_nettype wire

>>> sim/tb_bps_patch_command_decoder.sv
// Testbench for bps_patch_command_decoder: streams one well-formed BPS patch body
// through the queue ports, predicts every descriptor and checks each result in order.
// Depends on bpd_pkg and the decoder RTL.
`default_nettype none
module tb_bps_patch_command_decoder;
	import bpd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} patch_item_t;

	localparam logic [7:0] MAGIC_SEQ [4] = '{8'h42, 8'h50, 8'h53, 8'h31};
	localparam int TARGET_BYTES = 930;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  patch_byte = '0;
	logic        body_end = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  kind;
	logic [31:0] write_address, read_address, target_size;
	logic [30:0] copy_length;
	logic [7:0]  literal_value;
	logic [2:0]  error_code;

	bps_patch_command_decoder uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.push(push), .full(full), .patch_byte(patch_byte), .body_end(body_end),
		.empty(empty), .pop(pop),
		.kind(kind), .write_address(write_address), .read_address(read_address),
		.copy_length(copy_length), .literal_value(literal_value),
		.target_size(target_size), .error_code(error_code)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("tb_bps_patch_command_decoder failed");
		$finish;
	end

	// decoder mirror state
	phase_t      dec_phase = P_MAGIC;
	logic [1:0]  magic_pos = '0;
	logic [63:0] vint_acc = '0;
	int          vint_groups = 0;
	logic [31:0] src_size_reg = '0;
	logic [31:0] out_offset = '0;
	logic [31:0] src_rel = '0;
	logic [31:0] tgt_rel = '0;
	logic [31:0] decl_size = '0;
	logic [31:0] cur_cmd = '0;
	logic [31:0] remaining = '0;

	result_t     descriptor_q[$];
	patch_item_t patch_q[$];
	patch_item_t cmd_bytes[$];
	int          mismatches = 0;
	int          fail_count = 0;

	function automatic logic [63:0] weight_now();
		return (vint_groups >= 10) ? 64'd0 : (64'd1 << (7 * vint_groups));
	endfunction

	// one varint byte; returns 1 when the number is complete
	function automatic bit vint_take(input logic [7:0] b);
		vint_acc = vint_acc + 64'(b[6:0]) * weight_now();
		if (b[7])
			return 1'b1;
		if (vint_groups < 10)
			vint_groups++;
		vint_acc = vint_acc + weight_now();
		return 1'b0;
	endfunction

	function automatic result_t make_result(kind_t k, logic [31:0] wa, logic [31:0] ra,
			logic [31:0] len, logic [7:0] lit, logic [31:0] ts, err_t ec);
		result_t r;
		r.kind = k;
		r.write_address = wa;
		r.read_address = ra;
		r.copy_length = len[30:0];
		r.literal_value = lit;
		r.target_size = ts;
		r.error_code = ec;
		return r;
	endfunction

	task automatic end_of_patch();
		if (out_offset != decl_size)
			descriptor_q.push_back(make_result(K_ERR, out_offset, 0, 0, 0, decl_size, E_DST));
		else
			descriptor_q.push_back(make_result(K_DONE, out_offset, 0, 0, 0, decl_size, E_NONE));
		dec_phase = P_HALT;
	endtask

	task automatic halt_with(err_t ec);
		descriptor_q.push_back(make_result(K_ERR, out_offset, 0, 0, 0, decl_size, ec));
		dec_phase = P_HALT;
	endtask

	// advance the mirror by one accepted byte
	task automatic decode_byte(input logic [7:0] b, input logic last);
		result_t r;
		bit      got;
		err_t    er;
		logic [31:0] v, len;
		got = 0;
		er = E_NONE;
		r = '0;
		if (dec_phase == P_HALT)
			return;
		if (dec_phase == P_FINISH) begin
			end_of_patch();
			return;
		end
		case (dec_phase)
			P_MAGIC: begin
				if (b != MAGIC_SEQ[magic_pos])
					er = E_MAGIC;
				else if (magic_pos == 2'd3) begin
					magic_pos = 0;
					vint_acc = 0;
					vint_groups = 0;
					dec_phase = P_SRC;
				end else
					magic_pos++;
			end
			P_SRC: if (vint_take(b)) begin
				v = vint_acc[31:0];
				vint_acc = 0;
				vint_groups = 0;
				if (v != src_size_reg)
					er = E_SRC;
				else
					dec_phase = P_DST;
			end
			P_DST: if (vint_take(b)) begin
				decl_size = vint_acc[31:0];
				vint_acc = 0;
				vint_groups = 0;
				r = make_result(K_HDR, 0, 0, 0, 0, decl_size, E_NONE);
				got = 1;
				dec_phase = P_META;
			end
			P_META: if (vint_take(b)) begin
				remaining = vint_acc[31:0];
				vint_acc = 0;
				vint_groups = 0;
				dec_phase = (remaining != 0) ? P_SKIP : P_CMD;
			end
			P_SKIP: begin
				remaining--;
				if (remaining == 0)
					dec_phase = P_CMD;
			end
			P_CMD: if (vint_take(b)) begin
				cur_cmd = vint_acc[31:0];
				vint_acc = 0;
				vint_groups = 0;
				len = (cur_cmd >> 2) + 1;
				case (cur_cmd[1:0])
					2'd0: begin
						r = make_result(K_SREAD, out_offset, out_offset, len, 0, 0, E_NONE);
						got = 1;
						out_offset += len;
					end
					2'd1: begin
						remaining = len;
						dec_phase = P_LIT;
					end
					default: dec_phase = P_REL;
				endcase
			end
			P_LIT: begin
				r = make_result(K_LIT, out_offset, 0, 1, b, 0, E_NONE);
				got = 1;
				out_offset++;
				remaining--;
				if (remaining == 0)
					dec_phase = P_CMD;
			end
			default: if (vint_take(b)) begin
				v = vint_acc[31:0];
				vint_acc = 0;
				vint_groups = 0;
				len = (cur_cmd >> 2) + 1;
				if (cur_cmd[1:0] == 2'd2) begin
					src_rel = v[0] ? src_rel - (v >> 1) : src_rel + (v >> 1);
					r = make_result(K_SCOPY, out_offset, src_rel, len, 0, 0, E_NONE);
					src_rel += len;
				end else begin
					tgt_rel = v[0] ? tgt_rel - (v >> 1) : tgt_rel + (v >> 1);
					r = make_result(K_TCOPY, out_offset, tgt_rel, len, 0, 0, E_NONE);
					tgt_rel += len;
				end
				got = 1;
				out_offset += len;
				dec_phase = P_CMD;
			end
		endcase
		if (er != E_NONE) begin
			halt_with(er);
			return;
		end
		if (last) begin
			if (dec_phase != P_CMD || vint_groups != 0) begin
				halt_with(E_TRUNC);
				return;
			end
			if (got) begin
				descriptor_q.push_back(r);
				dec_phase = P_FINISH;
				return;
			end
			end_of_patch();
			return;
		end
		if (got)
			descriptor_q.push_back(r);
	endtask

	// input side: one item per push handshake, random gaps with burst stretches
	int send_gap = 0;
	int sent = 0;
	always @(posedge clk) begin
		patch_item_t it;
		if (!push || !full) begin
			if (push) begin
				decode_byte(patch_byte, body_end);
				sent++;
			end
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (patch_q.size() > 0) begin
				it = patch_q.pop_front();
				push <= 1'b1;
				patch_byte <= it.data;
				body_end <= it.last;
				send_gap = ((sent / 80) % 3 == 1) ? 0 : $urandom_range(0, 5);
			end else
				push <= 1'b0;
		end
	end

	// result side: compare each popped descriptor with the oldest prediction
	int pop_wait = 0;
	int popped = 0;
	always @(posedge clk) begin
		result_t want, got_r;
		if (arst_n) begin
			if (pop && !empty) begin
				got_r = make_result(kind_t'(kind), write_address, read_address,
					{1'b0, copy_length}, literal_value, target_size, err_t'(error_code));
				if (descriptor_q.size() == 0) begin
					fail_count++;
					if (mismatches++ < 10)
						$display("unexpected descriptor kind %0d", kind);
				end else begin
					want = descriptor_q.pop_front();
					if (got_r != want) begin
						fail_count++;
						if (mismatches++ < 10)
							$display("mismatch at descriptor %0d: expected %h got %h",
								popped, want, got_r);
					end
				end
				popped++;
				pop_wait = ((popped / 60) % 3 == 2) ? 0 : $urandom_range(0, 5);
			end else if (pop_wait > 0)
				pop_wait--;
			pop <= (pop_wait == 0);
		end
	end

	task automatic push_byte(input logic [7:0] b, input bit to_cmds);
		patch_item_t it;
		it.data = b;
		it.last = 1'b0;
		if (to_cmds)
			cmd_bytes.push_back(it);
		else
			patch_q.push_back(it);
	endtask

	// BPS number encoding: every continuation subtracts one
	task automatic put_number(input logic [63:0] x, input bit to_cmds);
		logic [6:0] low;
		forever begin
			low = x[6:0];
			x = x >> 7;
			if (x == 0) begin
				push_byte({1'b1, low}, to_cmds);
				break;
			end
			push_byte({1'b0, low}, to_cmds);
			x = x - 1;
		end
	endtask

	task automatic put_relative(input logic [31:0] mag, input bit neg);
		put_number({31'd0, mag, neg}, 1'b1);
	endtask

	task automatic set_source_size(input logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		src_size_reg = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (patch_q.size() > 0 || push || descriptor_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	logic [31:0] gen_offset = '0;

	// one command; op and length field chosen by the caller
	task automatic put_command(input logic [1:0] op, input logic [29:0] lenf);
		put_number({32'd0, lenf, op}, 1'b1);
		gen_offset += 32'(lenf) + 1;
		if (op == 2'd1)
			for (int i = 0; i <= lenf; i++)
				push_byte(8'($urandom), 1'b1);
		else if (op != 2'd0)
			put_relative($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300),
				$urandom_range(0, 1));
	endtask

	initial begin
		logic [31:0] src_len;
		int meta_len;
		patch_item_t it;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed commands: every op, literal extremes, huge length, long offsets
		put_command(2'd0, 30'd0);
		// literal run of two bytes
		put_number({32'd0, 30'd1, 2'd1}, 1'b1);
		gen_offset += 2;
		push_byte(8'h00, 1'b1);
		push_byte(8'hff, 1'b1);
		put_number({32'd0, 30'd3, 2'd2}, 1'b1);
		gen_offset += 4;
		put_relative(32'hffff_ffff, 1'b1);
		put_number({32'd0, 30'h3fff_ffff, 2'd3}, 1'b1);
		gen_offset += 32'h4000_0000;
		put_relative(32'h7fff_ffff, 1'b0);
		put_number({32'd0, 30'd2, 2'd3}, 1'b1);
		gen_offset += 3;
		// offset spread over more than ten groups
		for (int i = 0; i < 11; i++)
			push_byte(8'h01, 1'b1);
		push_byte(8'h80, 1'b1);
		put_command(2'd0, 30'h3fff_ffff);

		// random commands, small lengths mostly, literal runs short
		while (cmd_bytes.size() < TARGET_BYTES) begin
			case ($urandom_range(0, 3))
				0: put_command(2'd1, 30'($urandom_range(0, 7)));
				1: put_command(2'd0, $urandom_range(0, 15) == 0 ? 30'($urandom)
					: 30'($urandom_range(0, 40)));
				2: put_command(2'd2, 30'($urandom_range(0, 40)));
				default: put_command(2'd3, $urandom_range(0, 15) == 0 ? 30'($urandom)
					: 30'($urandom_range(0, 40)));
			endcase
		end
		cmd_bytes[cmd_bytes.size() - 1].last = 1'b1;

		// magic under the reset value of the register
		set_source_size(32'd0);
		for (int i = 0; i < 4; i++)
			push_byte(MAGIC_SEQ[i], 1'b0);
		drain();
		set_source_size(32'hffff_ffff);
		drain();
		src_len = $urandom;
		set_source_size(src_len);

		meta_len = $urandom_range(0, 4);
		put_number({32'd0, src_len}, 1'b0);
		put_number({32'd0, gen_offset}, 1'b0);
		put_number(64'(meta_len), 1'b0);
		for (int i = 0; i < meta_len; i++)
			push_byte(8'($urandom), 1'b0);
		foreach (cmd_bytes[i])
			patch_q.push_back(cmd_bytes[i]);
		// trailing bytes: the first releases the final status, the rest are ignored
		for (int i = 0; i < 3; i++) begin
			it.data = 8'($urandom);
			it.last = 1'($urandom);
			patch_q.push_back(it);
		end
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && descriptor_q.size() == 0)
			$display("tb_bps_patch_command_decoder passed");
		else
			$display("tb_bps_patch_command_decoder failed");
		$finish;
	end

endmodule
`default_nettype wire
